/* rtl/core/enf_pkg.sv */
// Shared types and constants of the expiring notice list.
`default_nettype none

package enf_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int PTR_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = 6;
    localparam int TTL_W      = 15;
    localparam int ADDR_W     = 3;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 136;

    localparam logic [TTL_W-1:0] TTL_CAP      = 15'd30000;
    localparam logic [TTL_W-1:0] TTL_DEFAULT  = 15'd5000;
    localparam logic [CNT_W-1:0] LIVE_DEFAULT = 6'd8;
    localparam logic [CNT_W-1:0] LIVE_CAP     = 6'd32;
    localparam logic [6:0]       TITLE_CAP    = 7'd96;
    localparam logic [8:0]       BODY_CAP     = 9'd256;

    // Register index, taken from paddr[2].
    localparam logic REG_MAX_LIVE    = 1'b0;
    localparam logic REG_DEFAULT_TTL = 1'b1;

    localparam logic OP_POST  = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    localparam logic [1:0] KIND_INFO    = 2'd0;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Input item, last field (now_ms) in the lowest bits.
    typedef struct packed {
        logic [15:0] payload_tag;
        logic        source_present;
        logic [8:0]  body_length;
        logic [6:0]  title_length;
        logic [1:0]  kind_code;
        logic [31:0] ttl_request;
        logic [39:0] now_ms;
    } t_in;

    // One stored notice, entry_id in the lowest bits.
    typedef struct packed {
        logic             source;
        logic [8:0]       body_len;
        logic [6:0]       title_len;
        logic [15:0]      tag;
        logic [TTL_W-1:0] ttl;
        logic [1:0]       kind;
        logic [39:0]      stamp;
        logic [31:0]      id;
    } t_entry;

    localparam int IN_W      = $bits(t_in);
    localparam int ENTRY_W   = $bits(t_entry);
    localparam int IN_PAD_W  = IN_DATA_W - IN_W;
    localparam int OUT_PAD_W = OUT_DATA_W - ENTRY_W - CNT_W - 1;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_POST    = 8'b0000_0010,
        ST_SW_RD   = 8'b0000_0100,
        ST_SW_CHK  = 8'b0000_1000,
        ST_EM_RD   = 8'b0001_0000,
        ST_EM_LOAD = 8'b0010_0000,
        ST_EM_WAIT = 8'b0100_0000,
        ST_SPARE   = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/expiring_notice_fifo.sv */
// Top level of the expiring notice list: sequencer, circular store and ports.
// Usage:
//   The slave stream carries one operation per transaction: i_s_tuser 0 posts a
//   notice, 1 runs an expiry sweep. A transaction is taken only while the block
//   is idle; o_s_tready stays low until every result of the previous one has
//   been delivered. After a post, or a sweep that removed something, the whole
//   list goes out on the master stream, oldest first, o_m_tlast on the final
//   one; an empty list gives one marker with o_m_tuser 0.
//   A post writes the notice, then each listed notice is read, loaded and
//   offered in turn on the single read port of the notice memory. A sweep
//   reads and checks each live notice through the one shared expiry compare,
//   then lists the survivors the same way, or gives the empty marker.
//   A rejected post (zero title length) and a sweep that removes nothing return
//   to idle with no results.
//   The result sits in an output register; a stall on i_m_tready holds it and
//   the sequencer waits. Reset empties the list, sets the next id to 1 and
//   restores both registers (capacity 8, default lifetime 5000 ms). The notice
//   memory needs no clearing, since only slots below the live count are read.
//   The user must write APB configuration only while idle; it is not enforced.
`default_nettype none

module expiring_notice_fifo (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // now_ms, ttl_request, kind_code, title_length, body_length,
    // source_present, payload_tag (lowest bit up), zero padded
    input  wire logic [enf_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // operation
    input  wire logic                           i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // entry_id, stamp_ms, out_kind, out_ttl, out_tag, out_title_length,
    // out_body_length, out_source_present, list_count, dropped_oldest
    // (lowest bit up), zero padded
    output logic [enf_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // entry_valid
    output logic                                o_m_tuser,
    output logic                                o_m_tlast,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [enf_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    enf_pkg::t_state                    r_state, n_state;
    logic [enf_pkg::CNT_W-1:0]          r_max_live;
    logic [enf_pkg::TTL_W-1:0]          r_default_ttl;
    logic [enf_pkg::PTR_W-1:0]          r_head, n_head;
    logic [enf_pkg::CNT_W-1:0]          r_count, n_count;
    logic [31:0]                        r_next_id, n_next_id;
    logic [enf_pkg::CNT_W-1:0]          r_idx, n_idx;
    logic [enf_pkg::CNT_W-1:0]          r_wr, n_wr;
    logic                               r_changed, n_changed;
    logic                               r_dropped, n_dropped;
    enf_pkg::t_in                       r_in, n_in;
    logic                               r_m_valid, n_m_valid;
    enf_pkg::t_entry                    r_m_entry, n_m_entry;
    logic                               r_m_tuser, n_m_tuser;
    logic                               r_m_last, n_m_last;
    logic [enf_pkg::CNT_W-1:0]          r_m_count, n_m_count;
    logic                               r_m_dropped, n_m_dropped;

    enf_pkg::t_entry                    mem [enf_pkg::LIST_DEPTH];
    enf_pkg::t_entry                    r_rd_data;
    logic                               mem_we;
    logic [enf_pkg::PTR_W-1:0]          mem_wa;
    logic [enf_pkg::PTR_W-1:0]          mem_ra;
    enf_pkg::t_entry                    mem_wd;

    enf_pkg::t_in                       s_in;
    logic                               cfg_we;
    logic [enf_pkg::CNT_W-1:0]          cfg_live;
    logic [enf_pkg::TTL_W-1:0]          cfg_ttl;

    logic                               post_full;
    logic [enf_pkg::PTR_W-1:0]          post_head;
    logic [enf_pkg::CNT_W-1:0]          post_count;
    logic [enf_pkg::TTL_W-1:0]          post_ttl;
    enf_pkg::t_entry                    post_entry;
    logic                               expired;

    assign s_in = enf_pkg::t_in'(i_s_tdata[enf_pkg::IN_W-1:0]);

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb begin
        cfg_live = pwdata[enf_pkg::CNT_W-1:0];
        if (cfg_live == '0) begin
            cfg_live = enf_pkg::LIVE_DEFAULT;
        end else if (cfg_live > enf_pkg::LIVE_CAP) begin
            cfg_live = enf_pkg::LIVE_CAP;
        end
        cfg_ttl = pwdata[enf_pkg::TTL_W-1:0];
        if (cfg_ttl == '0) begin
            cfg_ttl = enf_pkg::TTL_DEFAULT;
        end else if (cfg_ttl > enf_pkg::TTL_CAP) begin
            cfg_ttl = enf_pkg::TTL_CAP;
        end
    end

    always_comb begin
        case (paddr[2])
            enf_pkg::REG_MAX_LIVE:    prdata = {{(32-enf_pkg::CNT_W){1'b0}}, r_max_live};
            enf_pkg::REG_DEFAULT_TTL: prdata = {{(32-enf_pkg::TTL_W){1'b0}}, r_default_ttl};
            default:                  prdata = '0;
        endcase
    end

    // Post: when full, evict the oldest by advancing the head, then append at the tail.
    assign post_full  = (r_count >= r_max_live) && (r_count != '0);
    assign post_head  = r_head + enf_pkg::PTR_W'(post_full);
    assign post_count = r_count - enf_pkg::CNT_W'(post_full);

    always_comb begin
        if (r_in.ttl_request == '0) begin
            post_ttl = r_default_ttl;
        end else if (r_in.ttl_request > {{(32-enf_pkg::TTL_W){1'b0}}, enf_pkg::TTL_CAP}) begin
            post_ttl = enf_pkg::TTL_CAP;
        end else begin
            post_ttl = r_in.ttl_request[enf_pkg::TTL_W-1:0];
        end
        post_entry.id     = r_next_id;
        post_entry.stamp  = r_in.now_ms;
        post_entry.ttl    = post_ttl;
        post_entry.kind   = (r_in.kind_code == enf_pkg::KIND_UNKNOWN) ?
                            enf_pkg::KIND_INFO : r_in.kind_code;
        post_entry.tag    = r_in.payload_tag;
        post_entry.title_len = (r_in.title_length > enf_pkg::TITLE_CAP) ?
                               enf_pkg::TITLE_CAP : r_in.title_length;
        post_entry.body_len  = (r_in.body_length > enf_pkg::BODY_CAP) ?
                               enf_pkg::BODY_CAP : r_in.body_length;
        post_entry.source = r_in.source_present;
    end

    // The shared expiry compare; the sum carries into a 41st bit.
    assign expired = {1'b0, r_in.now_ms} >=
                     ({1'b0, r_rd_data.stamp} + 41'(r_rd_data.ttl));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_changed   = r_changed;
        n_dropped   = r_dropped;
        n_in        = r_in;
        n_m_valid   = r_m_valid;
        n_m_entry   = r_m_entry;
        n_m_tuser   = r_m_tuser;
        n_m_last    = r_m_last;
        n_m_count   = r_m_count;
        n_m_dropped = r_m_dropped;
        mem_we      = 1'b0;
        mem_wa      = post_head + post_count[enf_pkg::PTR_W-1:0];
        mem_wd      = post_entry;
        mem_ra      = r_head + r_idx[enf_pkg::PTR_W-1:0];
        case (r_state)
            enf_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_in      = s_in;
                    n_idx     = '0;
                    n_wr      = '0;
                    n_changed = 1'b0;
                    n_dropped = 1'b0;
                    if (i_s_tuser == enf_pkg::OP_SWEEP) begin
                        n_state = enf_pkg::ST_SW_RD;
                    end else if (s_in.title_length != '0) begin
                        n_state = enf_pkg::ST_POST;
                    end
                end
            end
            enf_pkg::ST_POST: begin
                mem_we    = 1'b1;
                n_head    = post_head;
                n_count   = post_count + 1'b1;
                n_next_id = r_next_id + 1'b1;
                n_dropped = post_full;
                n_state   = enf_pkg::ST_EM_RD;
            end
            enf_pkg::ST_SW_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_wr;
                    n_idx   = '0;
                    if (!r_changed) begin
                        n_state = enf_pkg::ST_IDLE;
                    end else if (r_wr == '0) begin
                        // Everything expired: a single empty marker.
                        n_m_valid   = 1'b1;
                        n_m_entry   = '0;
                        n_m_tuser   = 1'b0;
                        n_m_last    = 1'b1;
                        n_m_count   = '0;
                        n_m_dropped = 1'b0;
                        n_state     = enf_pkg::ST_EM_WAIT;
                    end else begin
                        n_state = enf_pkg::ST_EM_RD;
                    end
                end else begin
                    n_state = enf_pkg::ST_SW_CHK;
                end
            end
            enf_pkg::ST_SW_CHK: begin
                // The write slot never passes the read slot, so compaction is in place.
                if (expired) begin
                    n_changed = 1'b1;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_head + r_wr[enf_pkg::PTR_W-1:0];
                    mem_wd = r_rd_data;
                    n_wr   = r_wr + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = enf_pkg::ST_SW_RD;
            end
            enf_pkg::ST_EM_RD: begin
                n_state = enf_pkg::ST_EM_LOAD;
            end
            enf_pkg::ST_EM_LOAD: begin
                n_m_valid   = 1'b1;
                n_m_entry   = r_rd_data;
                n_m_tuser   = 1'b1;
                n_m_last    = (r_idx + 1'b1) == r_count;
                n_m_count   = r_count;
                n_m_dropped = r_dropped;
                n_state     = enf_pkg::ST_EM_WAIT;
            end
            enf_pkg::ST_EM_WAIT: begin
                if (i_m_tready) begin
                    n_m_valid = 1'b0;
                    if (r_m_last) begin
                        n_state = enf_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = enf_pkg::ST_EM_RD;
                    end
                end
            end
            default: begin
                n_state = enf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= enf_pkg::ST_IDLE;
            r_max_live    <= enf_pkg::LIVE_DEFAULT;
            r_default_ttl <= enf_pkg::TTL_DEFAULT;
            r_head        <= '0;
            r_count       <= '0;
            r_next_id     <= 32'd1;
            r_m_valid     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_m_valid <= n_m_valid;
            if (cfg_we && pready) begin
                case (paddr[2])
                    enf_pkg::REG_MAX_LIVE:    r_max_live    <= cfg_live;
                    enf_pkg::REG_DEFAULT_TTL: r_default_ttl <= cfg_ttl;
                    default:                  r_max_live    <= r_max_live;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_wr        <= n_wr;
        r_changed   <= n_changed;
        r_dropped   <= n_dropped;
        r_in        <= n_in;
        r_m_entry   <= n_m_entry;
        r_m_tuser   <= n_m_tuser;
        r_m_last    <= n_m_last;
        r_m_count   <= n_m_count;
        r_m_dropped <= n_m_dropped;
    end

    // Notice memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    assign o_s_tready = (r_state == enf_pkg::ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{enf_pkg::OUT_PAD_W{1'b0}}, r_m_dropped, r_m_count, r_m_entry};
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_last;

endmodule

`default_nettype wire

/* rtl/core/enf_checker.sv */
// Port-level checks of the expiring notice list, bound to its top level.
`default_nettype none

module enf_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [enf_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                          o_m_tuser,
    input wire logic                          o_m_tlast
);

    logic [enf_pkg::CNT_W-1:0] count_field;

    assign count_field = o_m_tdata[enf_pkg::ENTRY_W +: enf_pkg::CNT_W];

    // No new transaction is taken while a result is on offer.
    a_no_accept_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is pending");

    // The empty marker stands alone and reports an empty list.
    a_marker_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && count_field == '0))
        else $error("empty marker without last or with a nonzero count");

    // A listed entry implies a nonempty list.
    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (count_field != '0))
        else $error("entry reported with a zero list count");

    // A broadcast does not end before its last result.
    a_broadcast_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> !o_s_tready)
        else $error("input ready in the middle of a broadcast");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind expiring_notice_fifo enf_checker u_enf_checker (.*);

`default_nettype wire
